>>> rtl/mfs_pkg.sv
// Shared types, codes and defaults for the multilevel feedback job scheduler.
// Used by mfs_cell and multilevel_feedback_job_scheduler; depends on nothing.
package mfs_pkg;

	localparam int DEF_MAX_JOBS  = 16;
	localparam int DEF_WAIT_BITS = 8;

	localparam logic [7:0] RST_QUANTUM_ONE   = 8'd5;
	localparam logic [7:0] RST_QUANTUM_TWO   = 8'd2;
	localparam logic [7:0] RST_QUANTUM_THREE = 8'd1;
	localparam logic [7:0] RST_AGE_LIMIT     = 8'd10;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_ENQ    = 2'd1,
		MODE_DEQ    = 2'd2,
		MODE_FINISH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_NOTFOUND = 2'd2,
		STS_KILLED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_QUANTUM_ONE   = 2'd0,
		CFG_QUANTUM_TWO   = 2'd1,
		CFG_QUANTUM_THREE = 2'd2,
		CFG_AGE_LIMIT     = 2'd3
	} cfg_index_t;

	// One waiting job; its wait counter travels beside it at its own width.
	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [1:0]  defpri;
		logic [1:0]  curpri;
		logic [15:0] stamp;
		logic        moved;
	} entry_t;

	function automatic logic [1:0] level_of(input logic [1:0] pri);
		return (pri == 2'd0) ? 2'd1 : pri;
	endfunction

endpackage

>>> rtl/mfs_cell.sv
// One slot of the job ring: holds a waiting job and hands it to its neighbor
// on every shift. Depends on mfs_pkg.
module mfs_cell #(
	parameter int WAIT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  mfs_pkg::entry_t      d_entry,
	input  logic [WAIT_BITS-1:0] d_wait,
	output mfs_pkg::entry_t      q_entry,
	output logic [WAIT_BITS-1:0] q_wait
);
	import mfs_pkg::*;

	entry_t               entry_q;
	logic [WAIT_BITS-1:0] wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			wait_q  <= '0;
		end else if (shift) begin
			entry_q <= d_entry;
			wait_q  <= d_wait;
		end
	end

	assign q_entry = entry_q;
	assign q_wait  = wait_q;

endmodule

>>> rtl/multilevel_feedback_job_scheduler.sv
// Three-level feedback job scheduler built on a ring of job cells.
// Ticks are handled one at a time.
// Each ring rotation (aging, restamp, command, select, switch) walks every cell past
// the head once. Reset (arst_n low) empties all slots, stops the running job,
// clears the id and arrival counters and loads the default quanta and age limit.
module multilevel_feedback_job_scheduler #(
	parameter int MAX_JOBS  = mfs_pkg::DEF_MAX_JOBS,
	parameter int WAIT_BITS = mfs_pkg::DEF_WAIT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // priority_req[1:0], job_id[17:2], zero pad
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // running_id, new_id, preempted_id, status, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mfs_pkg::*;

	localparam int PW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = (WAIT_BITS > 8) ? WAIT_BITS : 8;
	localparam logic [WAIT_BITS-1:0] WMAX = {WAIT_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE, ST_AGE, ST_RESTAMP, ST_CMD, ST_SEL, ST_DECIDE, ST_SWITCH, ST_DONE
	} state_t;

	state_t state_q;

	// ring
	entry_t               cell_e [MAX_JOBS];
	logic [WAIT_BITS-1:0] cell_w [MAX_JOBS];
	entry_t               wb;
	logic [WAIT_BITS-1:0] wbw;
	logic                 shift;

	genvar g;
	generate
		for (g = 0; g < MAX_JOBS; g++) begin : g_cell
			if (g == MAX_JOBS - 1) begin : g_tail
				mfs_cell #(.WAIT_BITS(WAIT_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.d_entry(wb), .d_wait(wbw),
					.q_entry(cell_e[g]), .q_wait(cell_w[g])
				);
			end else begin : g_body
				mfs_cell #(.WAIT_BITS(WAIT_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.d_entry(cell_e[g+1]), .d_wait(cell_w[g+1]),
					.q_entry(cell_e[g]), .q_wait(cell_w[g])
				);
			end
		end
	endgenerate

	// registers
	logic [PW-1:0] pos_q, tgt_q;
	logic [7:0]    q1_q, q2_q, q3_q, age_lim_q;
	mode_t         mode_q;
	logic [1:0]    pri_q;
	logic [15:0]   jid_q;
	logic          run_valid_q;
	logic [15:0]   run_id_q;
	logic [1:0]    run_def_q, run_cur_q;
	logic [7:0]    turn_q;
	logic [15:0]   id_q, arr_q, stamp_w_q;
	status_t       status_q;
	logic [15:0]   new_id_q, pre_q;
	logic          grab_q, found_q;
	logic          bm_found_q;
	logic [PW-1:0] bm_pos_q;
	logic [15:0]   bm_age_q;
	logic          wok_q;
	logic [2:0]    b_found_q;
	logic [PW-1:0] b_pos_q  [3];
	logic [1:0]    b_cur_q  [3];
	logic [WAIT_BITS-1:0] b_wait_q [3];
	logic [15:0]   b_age_q  [3];
	logic [55:0]   out_q;
	logic          out_valid_q;

	// head processing
	entry_t               h;
	logic [WAIT_BITS-1:0] hw;
	logic [1:0]           lvl, rl;
	logic [15:0]          hage, wbage, idn;
	logic                 last, hit, mv_cand;
	logic [2:0]           cand;
	logic [WAIT_BITS-1:0] wnext;
	logic [7:0]           quant;

	assign h     = cell_e[0];
	assign hw    = cell_w[0];
	assign lvl   = level_of(h.curpri);
	assign rl    = level_of(run_cur_q);
	assign hage  = arr_q - h.stamp;
	assign wbage = arr_q - wb.stamp;
	assign last  = (pos_q == PW'(MAX_JOBS - 1));
	assign idn   = (id_q == 16'hFFFF) ? 16'd1 : id_q + 16'd1;
	assign wnext = (hw == WMAX) ? hw : hw + 1'b1;
	assign quant = (rl == 2'd1) ? q1_q : ((rl == 2'd2) ? q2_q : q3_q);
	assign shift = (state_q == ST_AGE) || (state_q == ST_RESTAMP) || (state_q == ST_CMD)
		|| (state_q == ST_SEL) || (state_q == ST_SWITCH);

	always_comb begin
		wb  = h;
		wbw = hw;
		hit = 1'b0;
		case (state_q)
			ST_AGE: begin
				wb.moved = 1'b0;
				if (h.valid) begin
					wbw = wnext;
					if (lvl < 2'd3 && CW'(wnext) >= CW'(age_lim_q)) begin
						wb.curpri = h.curpri + 2'd1;
						wbw       = '0;
						wb.moved  = (level_of(h.curpri + 2'd1) != lvl);
					end
				end
			end
			ST_RESTAMP: begin
				if (pos_q == tgt_q) begin
					wb.stamp = stamp_w_q;
					wb.moved = 1'b0;
				end
			end
			ST_CMD: begin
				if (mode_q == MODE_ENQ) begin
					if (!found_q && !h.valid) begin
						hit       = 1'b1;
						wb.valid  = 1'b1;
						wb.id     = idn;
						wb.defpri = pri_q;
						wb.curpri = pri_q;
						wb.stamp  = arr_q;
						wb.moved  = 1'b0;
						wbw       = '0;
					end
				end else if (!found_q && h.valid && h.id == jid_q) begin
					hit      = 1'b1;
					wb.valid = 1'b0;
				end
			end
			ST_SWITCH: begin
				if (pos_q == tgt_q) begin
					hit = 1'b1;
					if (run_valid_q) begin
						wb.valid  = 1'b1;
						wb.id     = run_id_q;
						wb.defpri = run_def_q;
						wb.curpri = run_def_q;
						wb.stamp  = arr_q;
						wb.moved  = 1'b0;
						wbw       = '0;
					end else begin
						wb.valid = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign mv_cand = wb.valid && wb.moved && (!bm_found_q || wbage > bm_age_q);

	// per-level candidate against the best so far; earlier slot wins ties
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			cand[l] = 1'b0;
			if (h.valid && lvl == 2'(l + 1)) begin
				if (!b_found_q[l])
					cand[l] = 1'b1;
				else if (l == 0 && h.curpri != b_cur_q[l])
					cand[l] = h.curpri > b_cur_q[l];
				else if (hw != b_wait_q[l])
					cand[l] = hw > b_wait_q[l];
				else
					cand[l] = hage > b_age_q[l];
			end
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q1_q      <= RST_QUANTUM_ONE;
			q2_q      <= RST_QUANTUM_TWO;
			q3_q      <= RST_QUANTUM_THREE;
			age_lim_q <= RST_AGE_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_QUANTUM_ONE:   q1_q      <= cfg_data;
				CFG_QUANTUM_TWO:   q2_q      <= cfg_data;
				CFG_QUANTUM_THREE: q3_q      <= cfg_data;
				CFG_AGE_LIMIT:     age_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			tgt_q       <= '0;
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			run_def_q   <= '0;
			run_cur_q   <= '0;
			turn_q      <= '0;
			id_q        <= '0;
			arr_q       <= '0;
			stamp_w_q   <= '0;
			mode_q      <= MODE_PLAIN;
			pri_q       <= '0;
			jid_q       <= '0;
			status_q    <= STS_OK;
			new_id_q    <= '0;
			pre_q       <= '0;
			grab_q      <= 1'b0;
			found_q     <= 1'b0;
			bm_found_q  <= 1'b0;
			bm_pos_q    <= '0;
			bm_age_q    <= '0;
			wok_q       <= 1'b0;
			b_found_q   <= '0;
			for (int l = 0; l < 3; l++) begin
				b_pos_q[l]  <= '0;
				b_cur_q[l]  <= '0;
				b_wait_q[l] <= '0;
				b_age_q[l]  <= '0;
			end
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			if (shift)
				pos_q <= last ? '0 : pos_q + 1'b1;
			if (state_q != ST_SEL && state_q != ST_DECIDE) begin
				b_found_q <= '0;
				wok_q     <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q     <= mode_t'(s_tuser);
						pri_q      <= s_tdata[1:0];
						jid_q      <= s_tdata[17:2];
						status_q   <= STS_OK;
						new_id_q   <= '0;
						pre_q      <= '0;
						grab_q     <= 1'b0;
						bm_found_q <= 1'b0;
						if (run_valid_q && turn_q != 8'hFF)
							turn_q <= turn_q + 8'd1;
						state_q <= ST_AGE;
					end
				end
				ST_AGE, ST_RESTAMP: begin
					if (mv_cand) begin
						bm_found_q <= 1'b1;
						bm_pos_q   <= pos_q;
						bm_age_q   <= wbage;
					end
					if (last) begin
						bm_found_q <= 1'b0;
						found_q    <= 1'b0;
						if (bm_found_q || mv_cand) begin
							// next promoted job in order of age takes a fresh stamp
							tgt_q     <= mv_cand ? pos_q : bm_pos_q;
							stamp_w_q <= arr_q;
							arr_q     <= arr_q + 16'd1;
							state_q   <= ST_RESTAMP;
						end else begin
							case (mode_q)
								MODE_ENQ: state_q <= ST_CMD;
								MODE_DEQ: begin
									if (run_valid_q && run_id_q == jid_q) begin
										run_valid_q <= 1'b0;
										status_q    <= STS_KILLED;
										state_q     <= ST_SEL;
									end else begin
										state_q <= ST_CMD;
									end
								end
								MODE_FINISH: begin
									run_valid_q <= 1'b0;
									state_q     <= ST_SEL;
								end
								default: state_q <= ST_SEL;
							endcase
						end
					end
				end
				ST_CMD: begin
					if (hit) begin
						found_q <= 1'b1;
						if (mode_q == MODE_ENQ) begin
							id_q     <= idn;
							new_id_q <= idn;
							arr_q    <= arr_q + 16'd1;
						end
					end
					if (last) begin
						if (mode_q == MODE_ENQ) begin
							if (!(found_q || hit))
								status_q <= STS_FULL;
							else
								grab_q <= run_valid_q && (pri_q > run_def_q);
						end else begin
							status_q <= (found_q || hit) ? STS_OK : STS_NOTFOUND;
						end
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (h.valid && lvl >= rl)
						wok_q <= 1'b1;
					for (int l = 0; l < 3; l++) begin
						if (cand[l]) begin
							b_found_q[l] <= 1'b1;
							b_pos_q[l]   <= pos_q;
							b_cur_q[l]   <= h.curpri;
							b_wait_q[l]  <= hw;
							b_age_q[l]   <= hage;
						end
					end
					if (last)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if ((grab_q || !run_valid_q || (turn_q >= quant && wok_q))
							&& (|b_found_q)) begin
						tgt_q   <= b_found_q[2] ? b_pos_q[2]
							: (b_found_q[1] ? b_pos_q[1] : b_pos_q[0]);
						state_q <= ST_SWITCH;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SWITCH: begin
					if (hit) begin
						if (run_valid_q) begin
							pre_q <= run_id_q;
							arr_q <= arr_q + 16'd1;
						end
						run_valid_q <= 1'b1;
						run_id_q    <= h.id;
						run_def_q   <= h.defpri;
						run_cur_q   <= h.curpri;
						turn_q      <= '0;
					end
					if (last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output word is free
					if (!out_valid_q || m_tready) begin
						out_q <= {6'd0, status_q, pre_q, new_id_q,
							run_valid_q ? run_id_q : 16'd0};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> pos_q == '0)
		else $error("ring not aligned at idle");

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_AGE)
		else $error("accepted tick did not start aging");

	a_new_id_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:16] != 16'd0 |-> m_tdata[49:48] == STS_OK)
		else $error("new id reported with non-ok status");

	a_switch_fills: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWITCH && hit |=> run_valid_q)
		else $error("switch left no running job");

endmodule

>>> test/tb.sv
// Self-checking bench for the multilevel feedback job scheduler: random and directed ticks,
// predicted tick by tick by a behavioral scheduler model and compared per output word.
// Depends on mfs_pkg and multilevel_feedback_job_scheduler.
`timescale 1ns / 100ps

module tb;
	import mfs_pkg::*;

	localparam int NJOBS = 16;
	localparam int WMAX = 255;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  pri;
		logic [15:0] jid;
	} tick_t;

	// first member sits in the top bits: status, preempted_id, new_id, running_id
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] preempted_id;
		logic [15:0] new_id;
		logic [15:0] running_id;
	} sched_out_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	multilevel_feedback_job_scheduler dut (.*);

	// scheduler shadow state
	logic        sl_valid [NJOBS];
	logic [15:0] sl_id [NJOBS];
	logic [1:0]  sl_def [NJOBS];
	logic [1:0]  sl_cur [NJOBS];
	int          sl_wait [NJOBS];
	logic [15:0] sl_stamp [NJOBS];
	logic        run_valid;
	logic [15:0] run_id;
	logic [1:0]  run_def, run_cur;
	int          run_turn;
	logic [15:0] id_ctr, arr_ctr;
	logic [7:0]  quantum [3];
	logic [7:0]  age_lim;

	tick_t      pending_ticks[$];
	sched_out_t expected_words[$];
	int errors = 0;
	int ticks_sent = 0;
	int wdog = 0;
	int hold_cycles = 0;
	bit sender_hold = 0;
	bit sink_block = 0;
	int send_gap = 0;
	int sink_gap = 0;

	function automatic int lvl(input logic [1:0] p);
		return (p == 2'd0) ? 1 : int'(p);
	endfunction

	function automatic logic [15:0] stamp_age(input logic [15:0] s);
		return arr_ctr - s;
	endfunction

	function automatic logic [15:0] next_stamp();
		logic [15:0] s;
		s = arr_ctr;
		arr_ctr = arr_ctr + 16'd1;
		return s;
	endfunction

	function automatic int pick_job();
		int best;
		for (int l = 3; l >= 1; l--) begin
			best = -1;
			for (int i = 0; i < NJOBS; i++) begin
				if (!sl_valid[i] || lvl(sl_cur[i]) != l) continue;
				if (best < 0) best = i;
				else if (l == 1 && sl_cur[i] != sl_cur[best]) begin
					if (sl_cur[i] > sl_cur[best]) best = i;
				end else if (sl_wait[i] != sl_wait[best]) begin
					if (sl_wait[i] > sl_wait[best]) best = i;
				end else if (stamp_age(sl_stamp[i]) > stamp_age(sl_stamp[best])) best = i;
			end
			if (best >= 0) return best;
		end
		return -1;
	endfunction

	function automatic void swap_in(input int idx, inout logic [15:0] pre);
		logic [15:0] pid;
		logic [1:0] pdef, pcur;
		if (idx < 0) return;
		pid = sl_id[idx];
		pdef = sl_def[idx];
		pcur = sl_cur[idx];
		sl_valid[idx] = 0;
		if (run_valid) begin
			pre = run_id;
			sl_valid[idx] = 1;
			sl_id[idx] = run_id;
			sl_def[idx] = run_def;
			sl_cur[idx] = run_def;
			sl_wait[idx] = 0;
			sl_stamp[idx] = next_stamp();
		end
		run_valid = 1;
		run_id = pid;
		run_def = pdef;
		run_cur = pcur;
		run_turn = 0;
	endfunction

	function automatic void sched_reset();
		for (int i = 0; i < NJOBS; i++) begin
			sl_valid[i] = 0; sl_id[i] = 0; sl_def[i] = 0; sl_cur[i] = 0;
			sl_wait[i] = 0; sl_stamp[i] = 0;
		end
		run_valid = 0; run_id = 0; run_def = 0; run_cur = 0; run_turn = 0;
		id_ctr = 0; arr_ctr = 0;
		quantum[0] = RST_QUANTUM_ONE;
		quantum[1] = RST_QUANTUM_TWO;
		quantum[2] = RST_QUANTUM_THREE;
		age_lim = RST_AGE_LIMIT;
	endfunction

	function automatic sched_out_t sched_tick(input tick_t t);
		sched_out_t o;
		logic moved [NJOBS];
		logic grab, any_ok;
		int l, s, best, q, rl;
		logic [15:0] pre;
		pre = 0;
		grab = 0;
		o = '0;
		if (run_valid && run_turn < 255) run_turn++;
		// age, promote, then restamp promoted jobs oldest first
		for (int i = 0; i < NJOBS; i++) begin
			moved[i] = 0;
			if (!sl_valid[i]) continue;
			l = lvl(sl_cur[i]);
			if (sl_wait[i] < WMAX) sl_wait[i]++;
			if (l < 3 && sl_wait[i] >= age_lim) begin
				sl_cur[i] = sl_cur[i] + 2'd1;
				sl_wait[i] = 0;
				if (lvl(sl_cur[i]) != l) moved[i] = 1;
			end
		end
		for (int n = 0; n < NJOBS; n++) begin
			best = -1;
			for (int i = 0; i < NJOBS; i++)
				if (moved[i] && (best < 0 || stamp_age(sl_stamp[i]) > stamp_age(sl_stamp[best])))
					best = i;
			if (best < 0) break;
			moved[best] = 0;
			sl_stamp[best] = next_stamp();
		end
		case (mode_t'(t.mode))
			MODE_ENQ: begin
				s = -1;
				for (int i = NJOBS - 1; i >= 0; i--) if (!sl_valid[i]) s = i;
				if (s < 0) o.status = STS_FULL;
				else begin
					id_ctr = id_ctr + 16'd1;
					if (id_ctr == 0) id_ctr = 1;
					o.new_id = id_ctr;
					sl_valid[s] = 1; sl_id[s] = id_ctr; sl_def[s] = t.pri; sl_cur[s] = t.pri;
					sl_wait[s] = 0; sl_stamp[s] = next_stamp();
					if (run_valid && t.pri > run_def) grab = 1;
				end
			end
			MODE_DEQ: begin
				if (run_valid && run_id == t.jid) begin
					run_valid = 0;
					o.status = STS_KILLED;
				end else begin
					o.status = STS_NOTFOUND;
					for (int i = 0; i < NJOBS; i++)
						if (o.status == STS_NOTFOUND && sl_valid[i] && sl_id[i] == t.jid) begin
							sl_valid[i] = 0;
							o.status = STS_OK;
						end
				end
			end
			MODE_FINISH: run_valid = 0;
			default: ;
		endcase
		if (grab || !run_valid) swap_in(pick_job(), pre);
		else begin
			rl = lvl(run_cur);
			q = quantum[rl - 1];
			any_ok = 0;
			for (int i = 0; i < NJOBS; i++)
				if (sl_valid[i] && lvl(sl_cur[i]) >= rl) any_ok = 1;
			if (run_turn >= q && any_ok) swap_in(pick_job(), pre);
		end
		o.running_id = run_valid ? run_id : 16'd0;
		o.preempted_id = pre;
		return o;
	endfunction

	function automatic int live_count();
		int n;
		n = run_valid;
		for (int i = 0; i < NJOBS; i++) n += sl_valid[i];
		return n;
	endfunction

	// pick a dequeue target: mostly a live job, sometimes a random or zero id
	function automatic logic [15:0] some_id();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'($urandom);
		if (r < 4 && run_valid) return run_id;
		for (int k = 0; k < 8; k++) begin
			r = $urandom_range(0, NJOBS - 1);
			if (sl_valid[r]) return sl_id[r];
		end
		return id_ctr;
	endfunction

	function automatic tick_t mk(input mode_t m, input logic [1:0] p, input logic [15:0] j);
		tick_t t;
		t.mode = m; t.pri = p; t.jid = j;
		return t;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_words.push_back(sched_tick(pending_ticks.pop_front()));
			ticks_sent++;
			send_gap <= $urandom_range(0, 15) * $urandom_range(0, 1);
			s_tvalid <= 0;
		end else if (!s_tvalid && send_gap > 0) begin
			send_gap <= send_gap - 1;
		end else if (!s_tvalid && !sender_hold && pending_ticks.size() > 0) begin
			s_tvalid <= 1;
			s_tuser <= pending_ticks[0].mode;
			s_tdata <= {6'd0, pending_ticks[0].jid, pending_ticks[0].pri};
		end
	end

	// monitor
	always @(posedge clk) begin
		sched_out_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[49:0];
			if (expected_words.size() == 0) begin
				$error("unexpected word %h", got);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got.running_id != want.running_id) begin
					$error("running_id exp %0d got %0d", want.running_id, got.running_id);
					errors++;
				end
				if (got.new_id != want.new_id) begin
					$error("new_id exp %0d got %0d", want.new_id, got.new_id);
					errors++;
				end
				if (got.preempted_id != want.preempted_id) begin
					$error("preempted_id exp %0d got %0d", want.preempted_id, got.preempted_id);
					errors++;
				end
				if (got.status != want.status) begin
					$error("status exp %0d got %0d", want.status, got.status);
					errors++;
				end
			end
			sink_gap <= $urandom_range(0, 15) * $urandom_range(0, 1);
			m_tready <= 0;
		end else if (sink_block || sink_gap > 0) begin
			if (sink_gap > 0) sink_gap <= sink_gap - 1;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			sink_block <= (hold_cycles > 1);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic drain();
		while (pending_ticks.size() > 0 || expected_words.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			CFG_QUANTUM_ONE: quantum[0] = v;
			CFG_QUANTUM_TWO: quantum[1] = v;
			CFG_QUANTUM_THREE: quantum[2] = v;
			default: age_lim = v;
		endcase
		@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			while (pending_ticks.size() > 2) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 40 && live_count() < NJOBS + 2)
				pending_ticks.push_back(mk(MODE_ENQ, 2'($urandom), 16'($urandom)));
			else if (r < 50)
				pending_ticks.push_back(mk(MODE_ENQ, 2'($urandom), 16'($urandom)));
			else if (r < 68)
				pending_ticks.push_back(mk(MODE_DEQ, 2'($urandom), some_id()));
			else if (r < 80)
				pending_ticks.push_back(mk(MODE_FINISH, 2'($urandom), 16'($urandom)));
			else
				pending_ticks.push_back(mk(MODE_PLAIN, 2'($urandom), 16'($urandom)));
			// keep predicting on accepted items only: wait until this one is taken
			while (pending_ticks.size() > 0) @(posedge clk);
		end
	endtask

	initial begin
		sched_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle ticks, finish while idle, every priority, fill, dequeue cases
		pending_ticks.push_back(mk(MODE_PLAIN, 2'd3, 16'hFFFF));
		pending_ticks.push_back(mk(MODE_FINISH, 2'd0, 16'd0));
		pending_ticks.push_back(mk(MODE_DEQ, 2'd0, 16'd0));
		pending_ticks.push_back(mk(MODE_ENQ, 2'd0, 16'hFFFF));
		pending_ticks.push_back(mk(MODE_ENQ, 2'd1, 16'd1));
		pending_ticks.push_back(mk(MODE_ENQ, 2'd2, 16'd0));
		pending_ticks.push_back(mk(MODE_ENQ, 2'd3, 16'd0));
		for (int i = 0; i < 15; i++)
			pending_ticks.push_back(mk(MODE_ENQ, 2'(i), 16'd0));
		pending_ticks.push_back(mk(MODE_DEQ, 2'd0, 16'd1));
		pending_ticks.push_back(mk(MODE_DEQ, 2'd0, 16'd4));
		pending_ticks.push_back(mk(MODE_DEQ, 2'd3, 16'hFFFF));
		drain();

		// receiver stalls long while the sender keeps offering
		hold_cycles <= 600;
		sink_block <= 1;
		random_phase(30);
		drain();

		write_reg(CFG_QUANTUM_ONE, 8'd1);
		write_reg(CFG_QUANTUM_TWO, 8'd255);
		write_reg(CFG_QUANTUM_THREE, 8'd3);
		write_reg(CFG_AGE_LIMIT, 8'd1);
		random_phase(250);
		drain();

		write_reg(CFG_QUANTUM_ONE, 8'd255);
		write_reg(CFG_QUANTUM_TWO, 8'd1);
		write_reg(CFG_QUANTUM_THREE, 8'd255);
		write_reg(CFG_AGE_LIMIT, 8'd255);
		random_phase(250);
		// sender pauses until all results are in
		sender_hold = 1;
		drain();
		sender_hold = 0;

		write_reg(CFG_QUANTUM_ONE, 8'($urandom_range(1, 8)));
		write_reg(CFG_QUANTUM_TWO, 8'($urandom_range(1, 8)));
		write_reg(CFG_QUANTUM_THREE, 8'($urandom_range(1, 8)));
		write_reg(CFG_AGE_LIMIT, 8'($urandom_range(2, 20)));
		random_phase(500);
		drain();

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
